/* rtl/core/vra_pkg.sv */
package vra_pkg;

    localparam int RANK_W  = 7;
    localparam int VALUE_W = 32;
    localparam int GROUP_W = 8;

    typedef struct packed {
        logic load;
        logic inc;
        logic add;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic              en;
        logic [RANK_W-1:0] tgt;
        logic [RANK_W-1:0] amt;
    } t_rank_add;

endpackage

/* rtl/core/vra_cell.sv */
module vra_cell
    import vra_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [RANK_W-1:0]         i_add_amt,
    input  logic [RANK_W-1:0]         i_next_count,
    output logic                      o_gt,
    output logic [RANK_W-1:0]         o_count
);

    logic signed [VALUE_W-1:0] r_value;
    logic [RANK_W-1:0]         r_count;
    logic [RANK_W-1:0]         n_count;

    assign o_gt    = r_value > i_value;
    assign o_count = r_count;

    always_comb begin
        n_count = r_count + {{(RANK_W-1){1'b0}}, i_ctl.inc} + (i_ctl.add ? i_add_amt : '0);
        if (i_ctl.load) begin
            n_count = '0;
        end else if (i_ctl.shift) begin
            n_count = i_next_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_value;
        end
        r_count <= n_count;
    end

endmodule

/* rtl/core/vra_rank_sum.sv */
module vra_rank_sum
    import vra_pkg::*;
#(
    parameter int N = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RANK_W-1:0] i_tgt,
    input  logic [N-1:0]      i_gt,
    output t_rank_add         o_add,
    output logic              o_pending
);

    localparam int NG  = (N + GROUP_W - 1) / GROUP_W;
    localparam int GSW = $clog2(GROUP_W + 1);

    logic [N-1:0]        r_gt;
    logic [RANK_W-1:0]   r_tgt1;
    logic                r_v1;
    logic [GSW-1:0]      r_grp [NG];
    logic [GSW-1:0]      n_grp [NG];
    logic [RANK_W-1:0]   r_tgt2;
    logic                r_v2;
    logic [RANK_W-1:0]   total;

    // group popcounts of the greater-than flags
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GROUP_W; b++) begin
                if (g * GROUP_W + b < N) begin
                    n_grp[g] = n_grp[g] + {{(GSW-1){1'b0}}, r_gt[g * GROUP_W + b]};
                end
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NG; g++) begin
            total = total + {{(RANK_W-GSW){1'b0}}, r_grp[g]};
        end
    end

    assign o_add.en   = r_v2;
    assign o_add.tgt  = r_tgt2;
    assign o_add.amt  = r_tgt2 - total;
    assign o_pending  = r_v1 | r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_gt   <= i_gt;
        r_tgt1 <= i_tgt;
        r_tgt2 <= r_tgt1;
        r_grp  <= n_grp;
    end

endmodule

/* rtl/core/value_rank_assigner_unit.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// input    | start high, busy low       | i_value, i_last_item
// result   | o_result_valid, one cycle  | o_rank, o_last_rank, o_dropped
//
// one value is taken per cycle while loading; each value is compared against
// every cell at once and the earlier-greater count settles through a two-stage
// popcount pipeline. after the last value, busy rises while the unit drains
// until the last add lands, then one result per stored value leaves cell 0
// each cycle as the chain shifts; busy stays high until the last result. reset
// is synchronous and clears the state, the fill and emit counts and the flags
// only. the receiver cannot stall results.
module value_rank_assigner_unit
    import vra_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last_item,
    output logic                      o_result_valid,
    output logic [RANK_W-1:0]         o_rank,
    output logic                      o_last_rank,
    output logic                      o_dropped
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [RANK_W-1:0]   r_count;
    logic [RANK_W-1:0]   r_emit;
    logic                r_overflow;

    logic                accept;
    logic                store_en;
    logic                emit_shift;
    logic [MAX_ELEMENTS-1:0] gt;
    logic [MAX_ELEMENTS-1:0] gt_masked;
    logic [RANK_W-1:0]   count [MAX_ELEMENTS];
    t_rank_add           add;
    logic                pending;

    assign busy       = r_state != S_LOAD;
    assign accept     = start && !busy;
    assign store_en   = accept && (r_count < RANK_W'(MAX_ELEMENTS));
    assign emit_shift = r_state == S_EMIT;

    for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
        t_cell_ctl         ctl;
        logic [RANK_W-1:0] next_count;

        assign gt_masked[k] = gt[k] && (RANK_W'(k) < r_count);
        assign ctl.load     = store_en && (r_count == RANK_W'(k));
        assign ctl.inc      = store_en && gt_masked[k];
        assign ctl.add      = add.en && (add.tgt == RANK_W'(k));
        assign ctl.shift    = emit_shift;

        if (k == MAX_ELEMENTS - 1) begin : g_tail
            assign next_count = '0;
        end else begin : g_link
            assign next_count = count[k+1];
        end

        vra_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_add_amt    (add.amt),
            .i_next_count (next_count),
            .o_gt         (gt[k]),
            .o_count      (count[k])
        );
    end

    vra_rank_sum #(
        .N (MAX_ELEMENTS)
    ) u_rank_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (store_en),
        .i_tgt     (r_count),
        .i_gt      (gt_masked),
        .o_add     (add),
        .o_pending (pending)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_count        <= '0;
            r_emit         <= '0;
            r_overflow     <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (store_en) begin
                            r_count <= r_count + RANK_W'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_last_item) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_emit <= '0;
                    if (!pending) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_result_valid <= 1'b1;
                    o_rank         <= count[0] + RANK_W'(1);
                    o_dropped      <= r_overflow;
                    o_last_rank    <= r_emit == r_count - RANK_W'(1);
                    r_emit         <= r_emit + RANK_W'(1);
                    if (r_emit == r_count - RANK_W'(1)) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* dv/value_rank_assigner_unit_tb.sv */
module value_rank_assigner_unit_tb;
    import vra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 64;
    localparam int ITEM_TARGET = 310;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {
        VALS_FULL,
        VALS_TIES,
        VALS_EDGES,
        VALS_MIXED
    } t_value_style;

    typedef logic signed [VALUE_W-1:0] t_value_q[$];

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              dropped;
    } t_rank_result;

    class rank_scoreboard;
        logic signed [VALUE_W-1:0] run_vals[$];
        bit                        run_dropped;
        t_rank_result              rank_q[$];
        int                        errors;

        function void note_input(logic signed [VALUE_W-1:0] val, logic last);
            t_rank_result res;
            int           cnt;
            if (run_vals.size() < CAPACITY) begin
                run_vals.push_back(val);
            end else begin
                run_dropped = 1'b1;
            end
            if (last) begin
                for (int k = 0; k < run_vals.size(); k++) begin
                    cnt = 1;
                    // ties go to the earlier arrival
                    for (int j = 0; j < run_vals.size(); j++) begin
                        if (run_vals[j] < run_vals[k] || (run_vals[j] == run_vals[k] && j < k)) begin
                            cnt++;
                        end
                    end
                    res.rank      = RANK_W'(cnt);
                    res.last_rank = (k == run_vals.size() - 1);
                    res.dropped   = run_dropped;
                    rank_q.push_back(res);
                end
                run_vals.delete();
                run_dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [RANK_W-1:0] rank, logic last_rank, logic dropped);
            t_rank_result exp_res;
            if (rank_q.size() == 0) begin
                $error("unexpected result: rank %0d last_rank %0d dropped %0d",
                       rank, last_rank, dropped);
                errors++;
                return;
            end
            exp_res = rank_q.pop_front();
            if (rank !== exp_res.rank) begin
                $error("rank: expected %0d, actual %0d", exp_res.rank, rank);
                errors++;
            end
            if (last_rank !== exp_res.last_rank) begin
                $error("last_rank: expected %0d, actual %0d", exp_res.last_rank, last_rank);
                errors++;
            end
            if (dropped !== exp_res.dropped) begin
                $error("dropped: expected %0d, actual %0d", exp_res.dropped, dropped);
                errors++;
            end
        endfunction

        function int pending();
            return rank_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      i_last_item = 1'b0;
    logic                      o_result_valid;
    logic [RANK_W-1:0]         o_rank;
    logic                      o_last_rank;
    logic                      o_dropped;

    rank_scoreboard sb;
    int             items_sent = 0;
    int             cycle_cnt = 0;

    value_rank_assigner_unit #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_last_item   (i_last_item),
        .o_result_valid(o_result_valid),
        .o_rank        (o_rank),
        .o_last_rank   (o_last_rank),
        .o_dropped     (o_dropped)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_rank, o_last_rank, o_dropped);
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value(t_value_style style);
        t_value_style s;
        s = (style == VALS_MIXED) ? t_value_style'($urandom_range(0, 2)) : style;
        case (s)
            VALS_TIES: begin
                return $signed(VALUE_W'($urandom_range(0, 6))) - 3;
            end
            VALS_EDGES: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $signed($urandom);
                endcase
            end
            default: begin
                return $signed($urandom);
            end
        endcase
    endfunction

    // one transaction; held start rides through the drain and emission phases
    task automatic send_item(logic signed [VALUE_W-1:0] val, logic last);
        int gap;
        bit quiet;
        quiet = (items_sent >= 100 && items_sent < 190);
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 37) begin
            gap++;
        end
        if (gap > 0) begin
            start       <= 1'b0;
            i_value     <= $signed($urandom);
            i_last_item <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_value     <= val;
        i_last_item <= last;
        do @(posedge i_clk); while (busy);
        sb.note_input(val, last);
        items_sent++;
    endtask

    task automatic send_list(t_value_q vals);
        for (int k = 0; k < vals.size(); k++) begin
            send_item(vals[k], k == vals.size() - 1);
        end
    endtask

    task automatic send_run(int len, t_value_style style);
        for (int k = 0; k < len; k++) begin
            send_item(pick_value(style), k == len - 1);
        end
    endtask

    initial begin
        int len;
        int sel;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_list('{VAL_MIN});
        send_list('{VAL_MAX, VAL_MIN, 0, -1, 1});
        send_list('{5, 5, -7, 5, 5});
        send_list('{32'shAAAA_AAAA, 32'sh5555_5555});
        send_list('{VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN});

        // overflow run, then a run that exactly fills the store
        send_run($urandom_range(CAPACITY + 1, CAPACITY + 8), VALS_MIXED);
        send_run(CAPACITY, VALS_FULL);
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                len = CAPACITY;
            end else if (sel == 1) begin
                len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            end else begin
                len = $urandom_range(1, 12);
            end
            send_run(len, t_value_style'($urandom_range(0, 3)));
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
